// ===== hdl/printable_varint_codec_assert.svh =====
// Assertion helpers for the printable varint codec.
`ifndef PRINTABLE_VARINT_CODEC_ASSERT_SVH
`define PRINTABLE_VARINT_CODEC_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PVC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pvc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PVC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pvc assertion failed");

`endif

// ===== hdl/pvc_pkg.sv =====
package pvc_pkg;

  localparam int VALUE_WIDTH_DEF = 32;

  localparam logic [7:0] TERMINATOR = 8'd96;
  localparam logic [7:0] POS_BASE   = 8'd64;
  localparam logic [7:0] NEG_BASE   = 8'd32;
  localparam logic [7:0] DIGIT_BASE = 8'd32;

  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  // Outcome of one decoded byte.
  typedef struct packed {
    logic emit;          // byte produces a result transaction
    logic value_valid;   // result carries a completed value
    logic format_error;  // result reports a rejected byte
  } dec_res_t;

endpackage

// ===== hdl/printable_varint_codec.sv =====
// Printable varint codec.
// Input channel (in_valid/in_ready): in_command selects encode (in_value_in)
// or decode of one byte (in_byte_in). Result channel (out_valid/out_ready)
// carries one byte, a decoded value or a format error per transaction;
// out_last marks the final result of an input transaction.
// Encode: the value is latched and negated if needed in the accept cycle,
// then a shared magnitude shifter peels off 5 and then 6 bits per cycle,
// one byte per cycle while the receiver is ready: 1 to 7 bytes at a
// 32-bit width; no new input is taken until the terminator is loaded.
// Decode: one byte per cycle while the receiver is not stalled; a lead or
// digit byte yields no result, a terminator yields the value, an out-of-range
// byte or one digit too many yields a format error and clears the decoder.
// A decode result appears in the cycle after acceptance (output register);
// an encode first enters S_ENC_LEAD, which then loads the first byte there.
// Reset (synchronous, rst_n low) clears the sequencer, the output valid flag
// and the decoder state. A stalled receiver holds the output register and
// the sequencer; no new input is taken until the register can be reloaded.
`include "printable_varint_codec_assert.svh"

module printable_varint_codec #(
  parameter int VALUE_WIDTH = pvc_pkg::VALUE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_command,
  input  logic signed [31:0] in_value_in,
  input  logic [7:0]         in_byte_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte_out,
  output logic               out_byte_valid,
  output logic signed [31:0] out_value_out,
  output logic               out_value_valid,
  output logic               out_format_error,
  output logic               out_last
);

  typedef enum logic [1:0] {S_IDLE, S_ENC_LEAD, S_ENC_DIGIT} state_t;

  state_t                 state_r, state_nxt;
  logic [VALUE_WIDTH-1:0] mag_r, mag_nxt;
  logic                   neg_r, neg_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        byte_r, byte_nxt;
  logic              byte_valid_r, byte_valid_nxt;
  logic signed [31:0] value_r, value_nxt;
  logic              value_valid_r, value_valid_nxt;
  logic              fmt_err_r, fmt_err_nxt;
  logic              last_r, last_nxt;

  logic                      load_ok;
  logic                      in_fire;
  logic                      dec_step;
  logic signed [VALUE_WIDTH-1:0] enc_v;
  logic signed [VALUE_WIDTH-1:0] dec_value_s;
  logic [VALUE_WIDTH-1:0]    dec_value;
  pvc_pkg::dec_res_t         dec_res;

  // Output register is free now or frees up at this edge.
  assign load_ok  = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && load_ok;
  assign in_fire  = in_valid && in_ready;
  assign dec_step = in_fire && (in_command == pvc_pkg::CMD_DECODE);

  assign enc_v       = VALUE_WIDTH'(in_value_in);
  assign dec_value_s = dec_value;

  pvc_dec #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dec (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (dec_step),
    .byte_in(in_byte_in),
    .res    (dec_res),
    .value  (dec_value)
  );

  always_comb begin
    state_nxt       = state_r;
    mag_nxt         = mag_r;
    neg_nxt         = neg_r;
    out_valid_nxt   = out_valid_r;
    byte_nxt        = byte_r;
    byte_valid_nxt  = byte_valid_r;
    value_nxt       = value_r;
    value_valid_nxt = value_valid_r;
    fmt_err_nxt     = fmt_err_r;
    last_nxt        = last_r;

    // drop the result once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_command == pvc_pkg::CMD_ENCODE) begin
            // latch sign and magnitude for the shifter
            neg_nxt   = enc_v[VALUE_WIDTH-1];
            mag_nxt   = enc_v[VALUE_WIDTH-1] ? (~enc_v + 1'b1) : enc_v;
            state_nxt = S_ENC_LEAD;
          end else if (dec_res.emit) begin
            out_valid_nxt   = 1'b1;
            byte_nxt        = '0;
            byte_valid_nxt  = 1'b0;
            value_nxt       = 32'(dec_value_s);
            value_valid_nxt = dec_res.value_valid;
            fmt_err_nxt     = dec_res.format_error;
            last_nxt        = 1'b1;
          end
        end
      end
      S_ENC_LEAD: begin
        if (load_ok) begin
          out_valid_nxt   = 1'b1;
          byte_valid_nxt  = 1'b1;
          value_nxt       = '0;
          value_valid_nxt = 1'b0;
          fmt_err_nxt     = 1'b0;
          if (mag_r == '0) begin
            // zero is the terminator alone
            byte_nxt  = pvc_pkg::TERMINATOR;
            last_nxt  = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            byte_nxt  = (neg_r ? pvc_pkg::NEG_BASE : pvc_pkg::POS_BASE) + 8'(mag_r[4:0]);
            last_nxt  = 1'b0;
            mag_nxt   = mag_r >> 5;
            state_nxt = S_ENC_DIGIT;
          end
        end
      end
      S_ENC_DIGIT: begin
        if (load_ok) begin
          out_valid_nxt   = 1'b1;
          byte_valid_nxt  = 1'b1;
          value_nxt       = '0;
          value_valid_nxt = 1'b0;
          fmt_err_nxt     = 1'b0;
          if (mag_r != '0) begin
            // advance one 6-bit digit
            byte_nxt = pvc_pkg::DIGIT_BASE + 8'(mag_r[5:0]);
            last_nxt = 1'b0;
            mag_nxt  = mag_r >> 6;
          end else begin
            byte_nxt  = pvc_pkg::TERMINATOR;
            last_nxt  = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mag_r         <= mag_nxt;
    neg_r         <= neg_nxt;
    byte_r        <= byte_nxt;
    byte_valid_r  <= byte_valid_nxt;
    value_r       <= value_nxt;
    value_valid_r <= value_valid_nxt;
    fmt_err_r     <= fmt_err_nxt;
    last_r        <= last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_byte_out     = byte_r;
  assign out_byte_valid   = byte_valid_r;
  assign out_value_out    = value_r;
  assign out_value_valid  = value_valid_r;
  assign out_format_error = fmt_err_r;
  assign out_last         = last_r;

  `PVC_ASSERT_NOW(a_busy_blocks_input, clk, rst_n, state_r != S_IDLE, !in_ready)
  `PVC_ASSERT_NEXT(a_encode_starts, clk, rst_n,
    in_fire && in_command == pvc_pkg::CMD_ENCODE, state_r == S_ENC_LEAD)
  `PVC_ASSERT_NOW(a_byte_excludes_value, clk, rst_n, out_valid && out_byte_valid,
    !out_value_valid && !out_format_error)
  `PVC_ASSERT_NOW(a_terminator_is_last, clk, rst_n, out_valid && out_byte_valid,
    out_last == (out_byte_out == pvc_pkg::TERMINATOR))

endmodule

// ===== hdl/pvc_dec.sv =====
module pvc_dec #(
  parameter int VALUE_WIDTH = pvc_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic [7:0]             byte_in,
  output pvc_pkg::dec_res_t      res,
  output logic [VALUE_WIDTH-1:0] value
);

  localparam int DigitLimit = (VALUE_WIDTH + 1) / 6;
  localparam int DPW        = $clog2(DigitLimit + 1);
  localparam int ShMax      = 5 + 6 * ((1 << DPW) - 1);
  localparam int SAW        = $clog2(ShMax + 1);

  logic [VALUE_WIDTH-1:0] acc_r, acc_nxt;
  logic [DPW-1:0]         pos_r, pos_nxt;
  logic                   neg_r, neg_nxt;
  logic                   in_num_r, in_num_nxt;

  logic [5:0]             digit;
  logic [SAW-1:0]         sh;
  logic [VALUE_WIDTH-1:0] weight;

  assign digit  = 6'(byte_in - pvc_pkg::DIGIT_BASE);
  assign sh     = SAW'(5) + SAW'({pos_r, 2'b00}) + SAW'({pos_r, 1'b0});
  assign weight = VALUE_WIDTH'(digit) << sh;

  always_comb begin
    acc_nxt    = acc_r;
    pos_nxt    = pos_r;
    neg_nxt    = neg_r;
    in_num_nxt = in_num_r;
    res        = '0;
    value      = '0;
    if (byte_in < pvc_pkg::DIGIT_BASE || byte_in > pvc_pkg::TERMINATOR) begin
      res.emit = 1'b1;
      res.format_error = 1'b1;
      acc_nxt = '0; pos_nxt = '0; neg_nxt = 1'b0; in_num_nxt = 1'b0;
    end else if (byte_in == pvc_pkg::TERMINATOR) begin
      res.emit = 1'b1;
      res.value_valid = 1'b1;
      if (in_num_r) begin
        value = neg_r ? (~acc_r + 1'b1) : acc_r;
      end
      acc_nxt = '0; pos_nxt = '0; neg_nxt = 1'b0; in_num_nxt = 1'b0;
    end else if (!in_num_r) begin
      // lead byte: sign and low five magnitude bits
      neg_nxt    = byte_in < pvc_pkg::POS_BASE;
      acc_nxt    = VALUE_WIDTH'(byte_in[4:0]);
      pos_nxt    = '0;
      in_num_nxt = 1'b1;
    end else if (pos_r >= DPW'(DigitLimit)) begin
      res.emit = 1'b1;
      res.format_error = 1'b1;
      acc_nxt = '0; pos_nxt = '0; neg_nxt = 1'b0; in_num_nxt = 1'b0;
    end else begin
      acc_nxt = acc_r + weight;
      pos_nxt = pos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      pos_r    <= '0;
      neg_r    <= 1'b0;
      in_num_r <= 1'b0;
    end else if (step) begin
      acc_r    <= acc_nxt;
      pos_r    <= pos_nxt;
      neg_r    <= neg_nxt;
      in_num_r <= in_num_nxt;
    end
  end

endmodule
